// ===== src/lbp_pkg.sv =====
`default_nettype none

package lbp_pkg;

	localparam int WORD_BITS = 32;
	localparam int BYTE_BITS = 8;
	localparam int COUNT_BITS = 6;
	localparam int LANES = WORD_BITS / BYTE_BITS;
	localparam int LANE_CNT_BITS = $clog2(LANES + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_FLUSH  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                  cmd;
		logic [WORD_BITS-1:0]  bits;
		logic [COUNT_BITS-1:0] bit_count;
	} field_req_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 last;
	} octet_req_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]     data;
		logic [LANE_CNT_BITS-1:0] nbytes;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

`default_nettype wire

// ===== src/lsb_first_bit_packer.sv =====
// Channel   Role     Handshake                  Payload
// field     input    field_valid/field_ready    field_req (cmd, bits, bit_count)
// octet     output   octet_valid/octet_ready    octet_req (out_byte, last)
//
// A request is taken every cycle while the two-entry queue has room; its
// bytes pass through the queue and then the output register. The back end
// sends one byte per cycle while the output is not stalled.
// Reset clears the partial byte, the queue and the output valid flag.
// A stall on the output fills the queue and then holds off field_ready.
`default_nettype none

module lsb_first_bit_packer #(
	parameter int MAX_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 field_valid,
	output logic                field_ready,
	input  lbp_pkg::field_req_t field_req,
	output logic                octet_valid,
	input  wire                 octet_ready,
	output lbp_pkg::octet_req_t octet_req
);

	lbp_pkg::push_t  push;
	logic            queue_full;
	logic            head_valid;
	lbp_pkg::entry_t head;
	logic            pop;

	lbp_front #(
		.MAX_BITS(MAX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.field_valid(field_valid),
		.field_ready(field_ready),
		.field_req  (field_req),
		.queue_full (queue_full),
		.push       (push)
	);

	lbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (queue_full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	lbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.octet_valid(octet_valid),
		.octet_ready(octet_ready),
		.octet_req  (octet_req)
	);

endmodule

`default_nettype wire

// ===== src/lbp_front.sv =====
`default_nettype none

module lbp_front #(
	parameter int MAX_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 field_valid,
	output logic                field_ready,
	input  lbp_pkg::field_req_t field_req,
	input  wire                 queue_full,
	output lbp_pkg::push_t      push
);

	localparam int LIMIT = (MAX_BITS > lbp_pkg::WORD_BITS) ? lbp_pkg::WORD_BITS : MAX_BITS;
	localparam logic [lbp_pkg::COUNT_BITS-1:0] LIMIT_CNT = lbp_pkg::COUNT_BITS'(LIMIT);
	localparam int ACC_BITS = lbp_pkg::WORD_BITS + lbp_pkg::BYTE_BITS;

	logic [lbp_pkg::BYTE_BITS-1:0]  partial_q;
	logic [2:0]                     pending_q;
	logic [lbp_pkg::COUNT_BITS-1:0] cnt;
	logic [lbp_pkg::WORD_BITS-1:0]  mask;
	logic [ACC_BITS-1:0]            combined;
	logic [ACC_BITS-1:0]            remain;
	logic [lbp_pkg::COUNT_BITS-1:0] total;
	logic [lbp_pkg::BYTE_BITS-1:0]  partial_d;
	logic [2:0]                     pending_d;
	logic                           accept;

	assign field_ready = !queue_full;
	assign accept = field_valid && field_ready;

	always_comb begin
		cnt = (field_req.bit_count > LIMIT_CNT) ? LIMIT_CNT : field_req.bit_count;
		mask = {lbp_pkg::WORD_BITS{1'b1}} >> (lbp_pkg::COUNT_BITS'(lbp_pkg::WORD_BITS) - cnt);
		combined = {{lbp_pkg::WORD_BITS{1'b0}}, partial_q}
			| ({{lbp_pkg::BYTE_BITS{1'b0}}, field_req.bits & mask} << pending_q);
		total = {3'b000, pending_q} + cnt;
		remain = combined >> {total[5:3], 3'b000};
		if (field_req.cmd == lbp_pkg::CMD_FLUSH) begin
			push.valid = accept && (pending_q != 3'd0);
			push.entry.data = {{(lbp_pkg::WORD_BITS - lbp_pkg::BYTE_BITS){1'b0}}, partial_q};
			push.entry.nbytes = lbp_pkg::LANE_CNT_BITS'(1);
			partial_d = '0;
			pending_d = '0;
		end else begin
			push.valid = accept && (total[5:3] != 3'd0);
			push.entry.data = combined[lbp_pkg::WORD_BITS-1:0];
			push.entry.nbytes = lbp_pkg::LANE_CNT_BITS'(total[5:3]);
			partial_d = remain[lbp_pkg::BYTE_BITS-1:0];
			pending_d = total[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= '0;
		end else if (accept) begin
			partial_q <= partial_d;
			pending_q <= pending_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/lbp_queue.sv =====
`default_nettype none

module lbp_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lbp_pkg::push_t       push,
	output logic                 full,
	output logic                 head_valid,
	output lbp_pkg::entry_t      head,
	input  wire                  pop
);

	localparam int CNT_BITS = $clog2(lbp_pkg::QUEUE_DEPTH + 1);
	localparam logic [lbp_pkg::QUEUE_AW-1:0] LAST_PTR =
		lbp_pkg::QUEUE_AW'(lbp_pkg::QUEUE_DEPTH - 1);

	lbp_pkg::entry_t               slot_q [lbp_pkg::QUEUE_DEPTH];
	logic [lbp_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [lbp_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]           count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full = (count_q == CNT_BITS'(lbp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/lbp_back.sv =====
`default_nettype none

module lbp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  lbp_pkg::entry_t     head,
	output logic                pop,
	output logic                octet_valid,
	input  wire                 octet_ready,
	output lbp_pkg::octet_req_t octet_req
);

	logic                                 valid_q;
	lbp_pkg::octet_req_t                  out_q;
	logic [lbp_pkg::WORD_BITS-1:0]        rem_q;
	logic [lbp_pkg::LANE_CNT_BITS-1:0]    left_q;
	logic                                 advance;

	assign octet_valid = valid_q;
	assign octet_req = out_q;
	assign advance = !valid_q || octet_ready;
	assign pop = advance && (left_q == '0) && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q <= '0;
		end else if (advance) begin
			if (left_q != '0) begin
				valid_q <= 1'b1;
				left_q <= left_q - 1'b1;
			end else if (head_valid) begin
				valid_q <= 1'b1;
				left_q <= head.nbytes - 1'b1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (left_q != '0) begin
				out_q.out_byte <= rem_q[lbp_pkg::BYTE_BITS-1:0];
				out_q.last <= (left_q == lbp_pkg::LANE_CNT_BITS'(1));
				rem_q <= rem_q >> lbp_pkg::BYTE_BITS;
			end else if (head_valid) begin
				out_q.out_byte <= head.data[lbp_pkg::BYTE_BITS-1:0];
				out_q.last <= (head.nbytes == lbp_pkg::LANE_CNT_BITS'(1));
				rem_q <= head.data >> lbp_pkg::BYTE_BITS;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/lbp_checker.sv =====
`default_nettype none

module lbp_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 field_valid,
	input wire                 field_ready,
	input lbp_pkg::field_req_t field_req,
	input wire                 octet_valid,
	input wire                 octet_ready,
	input lbp_pkg::octet_req_t octet_req
);

	// A stalled byte stays on the port unchanged.
	a_octet_hold: assert property (@(posedge clk) disable iff (!arst_n)
		octet_valid && !octet_ready |=> octet_valid && $stable(octet_req))
		else $error("octet request changed while stalled");

	// With the output empty the queue cannot be full.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!octet_valid |-> field_ready)
		else $error("field_ready low while no byte is pending");

	// The bytes of one request leave without gaps.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		octet_valid && octet_ready && !octet_req.last |=> octet_valid)
		else $error("gap inside the bytes of one request");

	// A waiting request stays on the port unchanged.
	a_field_hold: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && !field_ready |=> field_valid && $stable(field_req))
		else $error("field request changed while waiting");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.field_valid(field_valid),
	.field_ready(field_ready),
	.field_req  (field_req),
	.octet_valid(octet_valid),
	.octet_ready(octet_ready),
	.octet_req  (octet_req)
);

`default_nettype wire

// ===== tb/sv/lsb_first_bit_packer_test.sv =====
`default_nettype none

module lsb_first_bit_packer_test;

	localparam int MAX_BITS = 32;
	localparam int FIELD_LIMIT =
		(MAX_BITS < lbp_pkg::WORD_BITS) ? MAX_BITS : lbp_pkg::WORD_BITS;
	localparam int RANDOM_REQUESTS = 190;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		lbp_pkg::field_req_t               req;
		bit                                typed;
		int                                n_bytes;
		logic [3:0][lbp_pkg::BYTE_BITS-1:0] bytes;
	} stim_row_t;

	logic                logic_unused_guard;
	logic                clk;
	logic                arst_n;
	logic                field_valid;
	logic                field_ready;
	lbp_pkg::field_req_t field_req;
	logic                octet_valid;
	logic                octet_ready;
	lbp_pkg::octet_req_t octet_req;

	logic [lbp_pkg::BYTE_BITS-1:0] held_byte;
	logic [2:0]                    held_count;
	lbp_pkg::octet_req_t           packed_now[$];
	lbp_pkg::octet_req_t           expected_octets[$];
	stim_row_t                     rows_in_flight[$];
	stim_row_t                     directed_rows[$];
	stim_row_t                     accepted_row;
	lbp_pkg::octet_req_t           oldest;
	int                            mismatches = 0;
	bit                            hold_off_req = 1'b0;
	bit                            steady = 1'b0;

	lsb_first_bit_packer #(
		.MAX_BITS(MAX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.field_valid(field_valid),
		.field_ready(field_ready),
		.field_req(field_req),
		.octet_valid(octet_valid),
		.octet_ready(octet_ready),
		.octet_req(octet_req)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void pack_bits(lbp_pkg::field_req_t r);
		int n;
		packed_now.delete();
		if (r.cmd == lbp_pkg::CMD_FLUSH) begin
			if (held_count != 3'd0)
				packed_now.push_back('{out_byte: held_byte, last: 1'b0});
			held_byte = '0;
			held_count = '0;
		end else begin
			n = int'(r.bit_count);
			if (n > FIELD_LIMIT)
				n = FIELD_LIMIT;
			for (int i = 0; i < n; i++) begin
				held_byte[held_count] = r.bits[i];
				if (held_count == 3'd7) begin
					packed_now.push_back('{out_byte: held_byte, last: 1'b0});
					held_byte = '0;
					held_count = '0;
				end else begin
					held_count = held_count + 3'd1;
				end
			end
		end
		if (packed_now.size() > 0)
			packed_now[packed_now.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_row(lbp_pkg::cmd_t c, logic [31:0] w, logic [5:0] cnt,
			bit typed, int n, logic [31:0] b);
		stim_row_t s;
		s.req.cmd = c;
		s.req.bits = w;
		s.req.bit_count = cnt;
		s.typed = typed;
		s.n_bytes = n;
		s.bytes = b;
		directed_rows.push_back(s);
	endfunction

	function automatic lbp_pkg::field_req_t random_field();
		lbp_pkg::field_req_t r;
		int unsigned pick;
		r.cmd = ($urandom_range(99) < 15) ? lbp_pkg::CMD_FLUSH : lbp_pkg::CMD_APPEND;
		case ($urandom_range(7))
			0: r.bits = '0;
			1: r.bits = '1;
			default: r.bits = $urandom();
		endcase
		pick = $urandom_range(99);
		if (pick < 10)
			r.bit_count = 6'($urandom_range(63, 33));
		else if (pick < 20)
			r.bit_count = 6'd32;
		else if (pick < 60)
			r.bit_count = 6'($urandom_range(8, 1));
		else
			r.bit_count = 6'($urandom_range(32, 0));
		return r;
	endfunction

	task automatic send_request(input stim_row_t s);
		while (!steady && $urandom_range(99) < 17) begin
			field_valid <= 1'b0;
			@(negedge clk);
		end
		rows_in_flight.push_back(s);
		field_valid <= 1'b1;
		field_req <= s.req;
		@(posedge clk);
		while (!field_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && octet_valid && octet_ready) begin
			if (expected_octets.size() == 0) begin
				$error("unexpected octet: out_byte %02h last %0b", octet_req.out_byte,
					octet_req.last);
				mismatches++;
			end else begin
				oldest = expected_octets.pop_front();
				if (octet_req.out_byte !== oldest.out_byte) begin
					$error("out_byte: expected %02h, actual %02h", oldest.out_byte,
						octet_req.out_byte);
					mismatches++;
				end
				if (octet_req.last !== oldest.last) begin
					$error("last: expected %0b, actual %0b", oldest.last, octet_req.last);
					mismatches++;
				end
			end
		end
		if (arst_n && field_valid && field_ready) begin
			accepted_row = rows_in_flight.pop_front();
			pack_bits(field_req);
			if (accepted_row.typed) begin
				for (int k = 0; k < accepted_row.n_bytes; k++)
					expected_octets.push_back('{out_byte: accepted_row.bytes[k],
						last: (k == accepted_row.n_bytes - 1)});
			end else begin
				foreach (packed_now[k])
					expected_octets.push_back(packed_now[k]);
			end
		end
	end

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		octet_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				octet_ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				octet_ready <= 1'b1;
			end else begin
				octet_ready <= ($urandom_range(99) >= 17);
			end
		end
	end

	initial begin
		stim_row_t s;
		int effective;
		int iter;
		field_valid = 1'b0;
		field_req = '0;
		arst_n = 1'b0;
		held_byte = '0;
		held_count = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_row(lbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd0,  1'b1, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b1, 4, 32'hFFFF_FFFF);
		add_row(lbp_pkg::CMD_APPEND, 32'h0000_0000, 6'd63, 1'b1, 4, 32'h0000_0000);
		add_row(lbp_pkg::CMD_APPEND, 32'hA5A5_A5A5, 6'd40, 1'b1, 4, 32'hA5A5_A5A5);
		add_row(lbp_pkg::CMD_APPEND, 32'h0000_0005, 6'd3,  1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 1, 32'h0000_0005);
		add_row(lbp_pkg::CMD_FLUSH,  32'hFFFF_FFFF, 6'd32, 1'b1, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd1,  1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'hFFFF_FFFE, 6'd7,  1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'h0000_001F, 6'd5,  1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'h1234_5678, 6'd32, 1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_FLUSH,  32'hFFFF_FFFF, 6'd32, 1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'h8000_0001, 6'd33, 1'b1, 4, 32'h8000_0001);
		add_row(lbp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd7,  1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'h0000_0000, 6'd32, 1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'h5555_5555, 6'd31, 1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_FLUSH,  32'h0000_0000, 6'd0,  1'b0, 0, 32'h0);
		add_row(lbp_pkg::CMD_APPEND, 32'hDEAD_BEEF, 6'd8,  1'b1, 1, 32'h0000_00EF);
		foreach (directed_rows[i])
			send_request(directed_rows[i]);

		effective = 0;
		iter = 0;
		while (effective < RANDOM_REQUESTS) begin
			if (iter == 5)
				hold_off_req = 1'b1;
			if (iter == 60) begin
				field_valid <= 1'b0;
				@(negedge clk);
				while (expected_octets.size() != 0)
					@(negedge clk);
			end
			steady = (iter >= 100 && iter < 150);
			s.req = random_field();
			s.typed = 1'b0;
			s.n_bytes = 0;
			s.bytes = '0;
			if (s.req.cmd == lbp_pkg::CMD_FLUSH || s.req.bit_count != 6'd0)
				effective++;
			send_request(s);
			iter++;
		end
		steady = 1'b0;

		field_valid <= 1'b0;
		@(negedge clk);
		while (expected_octets.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("lsb_first_bit_packer_test: clean");
		end else begin
			$display("lsb_first_bit_packer_test: errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("lsb_first_bit_packer_test: errors");
		$finish;
	end

endmodule

`default_nettype wire
